// ----- rtl/lkv_pkg.sv -----
// ----------------------------------------------------------------------------
// lkv_pkg
// shared types and constants for the lru key/value cache
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int KEY_W = 64;
    localparam int VAL_W = 64;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request opcodes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_EVICT
    } lkv_state_t;

    // recency table operations
    typedef enum logic [1:0] {
        AGE_NOP,
        AGE_PROMOTE,
        AGE_INSERT,
        AGE_EVICT
    } age_op_t;

    typedef struct packed {
        age_op_t op;
        logic    replace;   // insert reuses a valid slot, count unchanged
    } age_cmd_t;

    // what the key scan found
    typedef struct packed {
        logic hit;      // key matched a valid slot
        logic old1;     // slot with rank count-1 seen
        logic old2;     // slot with rank count-2 seen
        logic free;     // an invalid slot seen
    } scan_flags_t;

endpackage

// ----- rtl/lkv_ram.sv -----
// ----------------------------------------------------------------------------
// lkv_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lkv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/lkv_age_table.sv -----
// ----------------------------------------------------------------------------
// lkv_age_table
// valid bits, recency ranks and entry count, updated one operation a cycle
// ----------------------------------------------------------------------------
module lkv_age_table #(
    parameter int ENTRIES = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lkv_pkg::age_cmd_t            cmd,
    input  logic [$clog2(ENTRIES)-1:0]   slot,
    input  logic [$clog2(ENTRIES)-1:0]   limit,
    input  logic [$clog2(ENTRIES)-1:0]   rd_idx,
    output logic                         rd_valid,
    output logic [$clog2(ENTRIES)-1:0]   rd_age,
    output logic [$clog2(ENTRIES+1)-1:0] count
);

    import lkv_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int AGE_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES+1);

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [AGE_W-1:0]   age_reg  [ENTRIES];
    logic [AGE_W-1:0]   age_next [ENTRIES];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            age_next[i] = age_reg[i];
            case (cmd.op)
                AGE_PROMOTE:
                begin
                    if (IDX_W'(i) == slot)
                    begin
                        age_next[i] = '0;
                    end
                    else if (valid_reg[i] && (age_reg[i] < limit))
                    begin
                        age_next[i] = age_reg[i] + 1'b1;
                    end
                end
                AGE_INSERT:
                begin
                    if (IDX_W'(i) == slot)
                    begin
                        age_next[i]   = '0;
                        valid_next[i] = 1'b1;
                    end
                    else if (valid_reg[i])
                    begin
                        age_next[i] = age_reg[i] + 1'b1;
                    end
                end
                AGE_EVICT:
                begin
                    if (IDX_W'(i) == slot)
                    begin
                        age_next[i]   = '0;
                        valid_next[i] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        case (cmd.op)
            AGE_INSERT:
            begin
                if (!cmd.replace)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            AGE_EVICT:
            begin
                count_next = count_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    assign rd_valid = valid_reg[rd_idx];
    assign rd_age   = age_reg[rd_idx];
    assign count    = count_reg;

    // count tracks the number of valid slots
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("entry count differs from number of valid slots");

    // an eviction removes exactly one entry
    a_evict_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == AGE_EVICT |=> count_reg == CNT_W'($past(count_reg) - 1'b1))
        else $error("eviction did not lower the count by one");

    // an inserted slot is valid and most recent afterwards
    a_insert_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == AGE_INSERT |=> valid_reg[$past(slot)] && age_reg[$past(slot)] == '0)
        else $error("inserted slot not valid with rank zero");

endmodule

// ----- rtl/lkv_scan.sv -----
// ----------------------------------------------------------------------------
// lkv_scan
// key comparator and trackers, one stored entry examined per cycle while cmp_vld is high
// ----------------------------------------------------------------------------
module lkv_scan #(
    parameter int ENTRIES = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic                         cmp_vld,
    input  logic [$clog2(ENTRIES)-1:0]   cmp_idx,
    input  logic [lkv_pkg::KEY_W-1:0]    req_key,
    input  logic [lkv_pkg::KEY_W-1:0]    rd_key,
    input  logic [lkv_pkg::VAL_W-1:0]    rd_value,
    input  logic                         ent_valid,
    input  logic [$clog2(ENTRIES)-1:0]   ent_age,
    input  logic [$clog2(ENTRIES+1)-1:0] count,
    output lkv_pkg::scan_flags_t         flags,
    output logic [$clog2(ENTRIES)-1:0]   hit_slot,
    output logic [$clog2(ENTRIES)-1:0]   hit_age,
    output logic [lkv_pkg::VAL_W-1:0]    hit_value,
    output logic [$clog2(ENTRIES)-1:0]   old1_slot,
    output logic [$clog2(ENTRIES)-1:0]   old2_slot,
    output logic [$clog2(ENTRIES)-1:0]   free_slot
);

    import lkv_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES+1);

    scan_flags_t      flags_reg;
    logic [IDX_W-1:0] hit_slot_reg;
    logic [IDX_W-1:0] hit_age_reg;
    logic [VAL_W-1:0] hit_value_reg;
    logic [IDX_W-1:0] old1_slot_reg;
    logic [IDX_W-1:0] old2_slot_reg;
    logic [IDX_W-1:0] free_slot_reg;

    logic             key_eq;
    logic             is_old1;
    logic             is_old2;
    logic [CNT_W-1:0] age_ext;

    assign key_eq  = (rd_key == req_key);
    assign age_ext = CNT_W'(ent_age);
    assign is_old1 = ent_valid && (age_ext == CNT_W'(count - 1'b1));
    assign is_old2 = ent_valid && (count >= CNT_W'(2))
                     && (age_ext == CNT_W'(count - 2'd2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (clear)
        begin
            flags_reg <= '0;
        end
        else if (cmp_vld)
        begin
            if (ent_valid && key_eq)
            begin
                flags_reg.hit <= 1'b1;
            end
            if (is_old1)
            begin
                flags_reg.old1 <= 1'b1;
            end
            if (is_old2)
            begin
                flags_reg.old2 <= 1'b1;
            end
            if (!ent_valid)
            begin
                flags_reg.free <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_vld)
        begin
            if (ent_valid && key_eq && !flags_reg.hit)
            begin
                hit_slot_reg  <= cmp_idx;
                hit_age_reg   <= ent_age;
                hit_value_reg <= rd_value;
            end
            if (is_old1)
            begin
                old1_slot_reg <= cmp_idx;
            end
            if (is_old2)
            begin
                old2_slot_reg <= cmp_idx;
            end
            if (!ent_valid && !flags_reg.free)
            begin
                free_slot_reg <= cmp_idx;
            end
        end
    end

    assign flags     = flags_reg;
    assign hit_slot  = hit_slot_reg;
    assign hit_age   = hit_age_reg;
    assign hit_value = hit_value_reg;
    assign old1_slot = old1_slot_reg;
    assign old2_slot = old2_slot_reg;
    assign free_slot = free_slot_reg;

endmodule

// ----- rtl/lru_key_value_cache_unit.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// fully associative lru key/value store, one get or put per transaction
// ----------------------------------------------------------------------------
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   ---------------------------
//  request   opcode, key, write_value                start high while busy low
//  response  hit, read_value                         done high for one cycle
//  config    capacity_we, capacity_wdata             capacity_we high, no wait
//
//  a transaction scans every slot through the key memory read port, one slot
//  per cycle, then drains and updates (and evicts when a put miss needs it)
//  while busy stays high; done rises in the same cycle that busy drops, and a
//  new start can be taken in that same cycle.
//  reset clears valid bits, ranks, count and capacity (back to 16); the key
//  and value memories hold garbage until written and need no clearing pass.
//  the receiver cannot stall: each result is shown for exactly one cycle.
//
module lru_key_value_cache_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // request
    input  logic                       start,
    output logic                       busy,
    input  logic                       opcode,
    input  logic [lkv_pkg::KEY_W-1:0]  key,
    input  logic [lkv_pkg::VAL_W-1:0]  write_value,
    // response
    output logic                       done,
    output logic                       hit,
    output logic [lkv_pkg::VAL_W-1:0]  read_value,
    // capacity register
    input  logic                       capacity_we,
    input  logic [lkv_pkg::CAP_W-1:0]  capacity_wdata
);

    import lkv_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES+1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES-1);

    // sequencer
    lkv_state_t       state_reg;
    lkv_state_t       state_next;
    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] scan_idx_next;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic [IDX_W-1:0] victim_reg;
    logic [IDX_W-1:0] victim_next;

    // latched request
    logic             req_op_reg;
    logic [KEY_W-1:0] req_key_reg;
    logic [VAL_W-1:0] req_wval_reg;

    // response registers
    logic             done_reg;
    logic             done_next;
    logic             hit_reg;
    logic             hit_next;
    logic [VAL_W-1:0] read_value_reg;
    logic [VAL_W-1:0] read_value_next;

    logic [CAP_W-1:0] capacity_reg;

    // memories
    logic             key_we;
    logic             val_we;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_value;

    // recency table
    age_cmd_t         age_cmd;
    logic [IDX_W-1:0] age_slot;
    logic             ent_valid;
    logic [IDX_W-1:0] ent_age;
    logic [CNT_W-1:0] count;

    // scan results
    logic             accept;
    scan_flags_t      flags;
    logic [IDX_W-1:0] hit_slot;
    logic [IDX_W-1:0] hit_age;
    logic [VAL_W-1:0] hit_value;
    logic [IDX_W-1:0] old1_slot;
    logic [IDX_W-1:0] old2_slot;
    logic [IDX_W-1:0] free_slot;

    // put-miss decisions
    logic             full;
    logic [IDX_W-1:0] ins_slot;
    logic [CNT_W-1:0] count_after;
    logic             evict_needed;
    logic [IDX_W-1:0] evict_slot;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // ------------------------------------------------------------------
    // storage
    // ------------------------------------------------------------------
    lkv_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (wr_addr),
        .wdata (req_key_reg),
        .raddr (scan_idx_reg),
        .rdata (rd_key)
    );

    lkv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (wr_addr),
        .wdata (req_wval_reg),
        .raddr (scan_idx_reg),
        .rdata (rd_value)
    );

    lkv_age_table #(
        .ENTRIES (ENTRIES)
    ) u_age_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (age_cmd),
        .slot     (age_slot),
        .limit    (hit_age),
        .rd_idx   (cmp_idx_reg),
        .rd_valid (ent_valid),
        .rd_age   (ent_age),
        .count    (count)
    );

    // compare stage runs in the cycle after its memory address is issued
    lkv_scan #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (accept),
        .cmp_vld   (cmp_vld_reg),
        .cmp_idx   (cmp_idx_reg),
        .req_key   (req_key_reg),
        .rd_key    (rd_key),
        .rd_value  (rd_value),
        .ent_valid (ent_valid),
        .ent_age   (ent_age),
        .count     (count),
        .flags     (flags),
        .hit_slot  (hit_slot),
        .hit_age   (hit_age),
        .hit_value (hit_value),
        .old1_slot (old1_slot),
        .old2_slot (old2_slot),
        .free_slot (free_slot)
    );

    // ------------------------------------------------------------------
    // put-miss slot choice and follow-up eviction
    // ------------------------------------------------------------------
    // full store: the oldest entry gives up its slot, otherwise the first free one
    assign full        = (count == CNT_W'(ENTRIES));
    assign ins_slot    = full ? old1_slot : free_slot;
    assign count_after = full ? count : CNT_W'(count + 1'b1);
    // capacity above ENTRIES never triggers, so no clamp is needed
    assign evict_needed = (CMP_W'(count_after) > CMP_W'(capacity_reg));
    // oldest after the insert: new entry if store was empty, second oldest if
    // the oldest was just replaced, else the previous oldest
    assign evict_slot = (count == '0) ? ins_slot
                      : (full ? old2_slot : old1_slot);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        victim_next     = victim_reg;
        done_next       = 1'b0;
        hit_next        = hit_reg;
        read_value_next = read_value_reg;
        age_cmd         = '{op: AGE_NOP, replace: 1'b0};
        age_slot        = hit_slot;
        key_we          = 1'b0;
        val_we          = 1'b0;
        wr_addr         = hit_slot;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    scan_idx_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // last compare lands this cycle
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next      = ST_IDLE;
                done_next       = 1'b1;
                hit_next        = flags.hit;
                read_value_next = '0;
                if (flags.hit)
                begin
                    // hit: promote, and a put rewrites the value in place
                    age_cmd.op = AGE_PROMOTE;
                    age_slot   = hit_slot;
                    wr_addr    = hit_slot;
                    if (req_op_reg == OP_PUT)
                    begin
                        val_we = 1'b1;
                    end
                    else
                    begin
                        read_value_next = hit_value;
                    end
                end
                else if (req_op_reg == OP_PUT)
                begin
                    age_cmd.op      = AGE_INSERT;
                    age_cmd.replace = full;
                    age_slot        = ins_slot;
                    wr_addr         = ins_slot;
                    key_we          = 1'b1;
                    val_we          = 1'b1;
                    if (evict_needed)
                    begin
                        // result waits for the eviction cycle
                        victim_next = evict_slot;
                        done_next   = 1'b0;
                        state_next  = ST_EVICT;
                    end
                end
            end
            ST_EVICT:
            begin
                age_cmd.op      = AGE_EVICT;
                age_slot        = victim_reg;
                state_next      = ST_IDLE;
                done_next       = 1'b1;
                hit_next        = 1'b0;
                read_value_next = '0;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            done_reg     <= 1'b0;
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            cmp_vld_reg  <= (state_reg == ST_SCAN);
            done_reg     <= done_next;
            if (capacity_we)
            begin
                capacity_reg <= capacity_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= scan_idx_reg;
        victim_reg     <= victim_next;
        hit_reg        <= hit_next;
        read_value_reg <= read_value_next;
        if (accept)
        begin
            req_op_reg   <= opcode;
            req_key_reg  <= key;
            req_wval_reg <= write_value;
        end
    end

    assign done       = done_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // a transaction taken leaves the sequencer busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted transaction did not start the scan");

    // a response only follows an update or eviction cycle
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_UPDATE || $past(state_reg) == ST_EVICT))
        else $error("response strobe without a finishing cycle");

    // eviction only straight after an insert
    a_evict_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EVICT |-> $past(state_reg) == ST_UPDATE
                                  && $past(age_cmd.op) == AGE_INSERT)
        else $error("eviction cycle not preceded by an insert");

    // an evicting put never reports a hit
    a_evict_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EVICT |=> done && !hit && read_value == '0)
        else $error("evicting put reported a hit or data");

endmodule

// ----- tb/tb_lru_key_value_cache_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_unit
// self-checking bench for the lru key/value cache: drives get and put
// transactions through the start/busy port, keeps its own recency model of
// the store, and checks hit and read_value of every done strobe in order
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_unit;

    import lkv_pkg::*;

    localparam int ENTRIES  = 16;
    localparam int POOL_MAX = 24;

    // one expected response
    typedef struct {
        logic             hit;
        logic [VAL_W-1:0] value;
    } cache_reply_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              opcode;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  write_value;
    logic              done;
    logic              hit;
    logic [VAL_W-1:0]  read_value;
    logic              capacity_we;
    logic [CAP_W-1:0]  capacity_wdata;

    // model of the store: slot contents, recency ranks (0 = newest), fill level
    logic [KEY_W-1:0]  slot_key  [ENTRIES];
    logic [VAL_W-1:0]  slot_val  [ENTRIES];
    logic              slot_used [ENTRIES];
    int unsigned       slot_rank [ENTRIES];
    int unsigned       used_count;
    logic [CAP_W-1:0]  cap_setting;

    cache_reply_t      pending_replies[$];
    int                replies_due;
    int                mismatch_count;
    logic [KEY_W-1:0]  key_pool[POOL_MAX];

    lru_key_value_cache_unit #(
        .ENTRIES        (ENTRIES)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .key            (key),
        .write_value    (write_value),
        .done           (done),
        .hit            (hit),
        .read_value     (read_value),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata)
    );

    // 4 ns clock
    always #2 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------------
    // recency model
    // ------------------------------------------------------------------------

    function automatic void clear_store();
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_key[i]  = '0;
            slot_val[i]  = '0;
            slot_used[i] = 1'b0;
            slot_rank[i] = 0;
        end
        used_count  = 0;
        cap_setting = CAP_RESET;
    endfunction

    // age every live slot younger than limit by one, then make slot s newest
    function automatic void raise_ranks(input int s, input int unsigned limit);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && slot_rank[i] < limit)
                slot_rank[i]++;
        slot_rank[s] = 0;
    endfunction

    // live slot with the highest rank, only meaningful when something is stored
    function automatic int oldest_slot();
        int          best;
        int unsigned best_rank;
        logic        found;
        best      = 0;
        best_rank = 0;
        found     = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && (!found || slot_rank[i] > best_rank))
            begin
                best      = i;
                best_rank = slot_rank[i];
                found     = 1'b1;
            end
        return best;
    endfunction

    // apply one request to the model and return the response it should give
    function automatic cache_reply_t cache_access(input logic op,
                                                  input logic [KEY_W-1:0] k,
                                                  input logic [VAL_W-1:0] v);
        cache_reply_t r;
        int           slot;
        int           victim;
        int unsigned  eff_cap;
        r.hit   = 1'b0;
        r.value = '0;
        slot    = 0;
        // anything above the slot count behaves like a full-size store
        eff_cap = (cap_setting > ENTRIES) ? ENTRIES : cap_setting;

        for (int i = 0; i < ENTRIES; i++)
            if (!r.hit && slot_used[i] && slot_key[i] == k)
            begin
                slot  = i;
                r.hit = 1'b1;
            end

        if (r.hit)
        begin
            raise_ranks(slot, slot_rank[slot]);
            if (op == OP_GET)
                r.value = slot_val[slot];
            else
                slot_val[slot] = v;
        end
        else if (op == OP_PUT)
        begin
            if (used_count >= ENTRIES)
            begin
                // every slot taken: the oldest one is reused for the new key
                slot            = oldest_slot();
                slot_used[slot] = 1'b0;
                used_count--;
            end
            else
            begin
                slot = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && !slot_used[i])
                        slot = i;
            end
            raise_ranks(slot, ENTRIES);
            slot_used[slot] = 1'b1;
            slot_key[slot]  = k;
            slot_val[slot]  = v;
            slot_rank[slot] = 0;
            used_count++;
            // over the capacity: drop exactly one entry, the oldest
            if (used_count > eff_cap)
            begin
                victim            = oldest_slot();
                slot_used[victim] = 1'b0;
                slot_rank[victim] = 0;
                used_count--;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // driving and checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // one transaction: optional idle cycles, then hold start until it is taken
    task automatic send_request(input logic op, input logic [KEY_W-1:0] k,
                                input logic [VAL_W-1:0] v, input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start       <= 1'b1;
        opcode      <= op;
        key         <= k;
        write_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // accepted at this edge: predict the response now
        pending_replies.insert(pending_replies.size(), cache_access(op, k, v));
        replies_due++;
    endtask

    // stop sending and let every outstanding response come back
    task automatic wait_until_idle();
        @(negedge clk);
        start <= 1'b0;
        wait (replies_due == 0);
    endtask

    // the block must be idle here: nothing in flight, no result pending
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_until_idle();
        @(negedge clk);
        capacity_we    <= 1'b1;
        capacity_wdata <= cap;
        @(negedge clk);
        capacity_we    <= 1'b0;
        cap_setting     = cap;
    endtask

    // response checker: every done strobe is matched against the oldest prediction
    always @(posedge clk)
    begin
        cache_reply_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_replies.size() == 0)
                report_mismatch("response with no transaction outstanding");
            else
            begin
                want = pending_replies.pop_front();
                replies_due--;
                if (hit !== want.hit)
                    report_mismatch($sformatf("hit %b, want %b", hit, want.hit));
                if (read_value !== want.value)
                    report_mismatch($sformatf("read_value %h, want %h",
                                              read_value, want.value));
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // gets and puts at the default capacity, extreme keys and values
    task automatic test_basic_ops();
        send_request(OP_GET, '0, '0, 0);                      // empty store miss
        send_request(OP_PUT, '0, '1, 0);                      // insert key zero
        send_request(OP_GET, '0, '0, 0);                      // hit, all ones back
        send_request(OP_PUT, '1, '0, 1);                      // insert all-ones key
        send_request(OP_PUT, '0, 64'h5555_5555_5555_5555, 0); // update in place
        send_request(OP_GET, '1, '1, 0);                      // hit, value zero
        send_request(OP_GET, '0, '0, 3);
        send_request(OP_PUT, 64'h8000_0000_0000_0001, 64'hAAAA_AAAA_AAAA_AAAA, 0);
        send_request(OP_GET, 64'hA5A5_5A5A_0F0F_F0F0, '1, 0); // unknown key miss
    endtask

    // capacity dropped below the fill level: one eviction per put miss only
    task automatic test_shrunk_capacity();
        set_capacity(5'd1);
        send_request(OP_PUT, 64'h0000_0000_0000_1234, 64'h1111, 0);
        send_request(OP_GET, 64'h0000_0000_0000_1234, '0, 0);
        send_request(OP_PUT, 64'h0000_0000_0000_5678, 64'h2222, 2);
        send_request(OP_GET, '0, '0, 0);
        send_request(OP_GET, '1, '0, 0);
    endtask

    // zero capacity: a put miss inserts and immediately evicts the oldest
    task automatic test_zero_capacity();
        set_capacity(5'd0);
        send_request(OP_PUT, 64'hDEAD_BEEF_0000_0001, 64'h3333, 0);
        send_request(OP_GET, 64'hDEAD_BEEF_0000_0001, '0, 0);
        send_request(OP_GET, 64'h0000_0000_0000_1234, '0, 0);
        send_request(OP_PUT, 64'h0000_0000_0000_5678, '1, 0);
    endtask

    // random gets and puts over a key pool a little larger than the capacity,
    // so hits, misses, updates and evictions all happen often
    task automatic test_random_traffic(input logic [CAP_W-1:0] cap, input int idle_pct,
                                       input int n_items, input logic drain_midway);
        int               pool_n;
        int               gap;
        logic             op;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        set_capacity(cap);
        pool_n = ((cap > ENTRIES) ? ENTRIES : cap) + 5;
        for (int i = 0; i < POOL_MAX; i++)
            key_pool[i] = rand64();
        for (int n = 0; n < n_items; n++)
        begin
            op = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 8)
                k = rand64();
            else
                k = key_pool[$urandom_range(0, pool_n - 1)];
            case ($urandom_range(0, 15))
                0:       v = '0;
                1:       v = '1;
                default: v = rand64();
            endcase
            if ($urandom_range(0, 99) < idle_pct)
                gap = $urandom_range(1, ENTRIES + 12);
            else
                gap = 0;
            // hold off once until the pipeline is completely empty
            if (drain_midway && n == n_items / 2)
                wait_until_idle();
            send_request(op, k, v, gap);
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        opcode         = OP_GET;
        key            = '0;
        write_value    = '0;
        capacity_we    = 1'b0;
        capacity_wdata = '0;
        replies_due    = 0;
        mismatch_count = 0;
        clear_store();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_shrunk_capacity();
        test_zero_capacity();

        // idle mix cycles through none, 55 percent and 21 percent
        test_random_traffic(5'd16, 0, 210, 1'b0);
        test_random_traffic(5'd31, 55, 210, 1'b0);
        test_random_traffic(5'd3, 0, 200, 1'b0);
        test_random_traffic(5'd0, 21, 200, 1'b0);
        test_random_traffic(5'd1, 55, 200, 1'b0);
        test_random_traffic(5'($urandom_range(2, 15)), 0, 210, 1'b1);
        test_random_traffic(5'd17, 21, 210, 1'b0);
        test_random_traffic(5'd8, 0, 200, 1'b0);

        wait_until_idle();
        repeat (ENTRIES + 4) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_lru_key_value_cache_unit passed");
        else
            $display("tb_lru_key_value_cache_unit failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("tb_lru_key_value_cache_unit failed");
        $finish;
    end

endmodule

// ----- lru_key_value_cache_unit.f -----
rtl/lkv_pkg.sv
rtl/lkv_ram.sv
rtl/lkv_age_table.sv
rtl/lkv_scan.sv
rtl/lru_key_value_cache_unit.sv
tb/tb_lru_key_value_cache_unit.sv
